FILE: hdl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, constants, weight tables and the blend function of the
// gradient palette shader.
// ----------------------------------------------------------------------------
package gps_pkg;

    // Frame size in pixels
    localparam int unsigned WIDTH  = 80;
    localparam int unsigned HEIGHT = 64;

    localparam int unsigned COL_SPAN = (WIDTH > 1) ? WIDTH - 1 : 1;
    localparam int unsigned ROW_SPAN = (HEIGHT > 1) ? HEIGHT - 1 : 1;

    // Input field widths
    localparam int unsigned COL_W  = 7;
    localparam int unsigned ROW_W  = 6;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned COLOR_W  = NUM_CHAN * CHAN_W;

    // Weights are 1.16 fixed point (one integer bit, 16 fraction bits) so that 1.0 is exact
    localparam int unsigned WEIGHT_W = 17;
    localparam longint unsigned ONE_Q16 = 65536;

    localparam int unsigned COL_ENTRIES = 1 << COL_W;
    localparam int unsigned ROW_ENTRIES = 1 << ROW_W;

    // APB register map
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [COLOR_W-1:0] UPPER_LEFT_RESET  = 24'hFFCE0D;
    localparam logic [COLOR_W-1:0] UPPER_RIGHT_RESET = 24'h52F49C;
    localparam logic [COLOR_W-1:0] LOWER_LEFT_RESET  = 24'hFF37AA;
    localparam logic [COLOR_W-1:0] LOWER_RIGHT_RESET = 24'h6A9AEB;

    typedef enum logic [1:0] {
        REG_UPPER_LEFT  = 2'd0,
        REG_UPPER_RIGHT = 2'd1,
        REG_LOWER_LEFT  = 2'd2,
        REG_LOWER_RIGHT = 2'd3
    } reg_index_t;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [CHAN_W-1:0]   chan_t;
    typedef weight_t [COL_ENTRIES-1:0] col_table_t;
    typedef weight_t [ROW_ENTRIES-1:0] row_table_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [CHAN_W-1:0] intensity;
    } pixel_t;

    typedef struct packed {
        logic              write_enable;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } shade_t;

    typedef struct packed {
        logic [COLOR_W-1:0] upper_left;
        logic [COLOR_W-1:0] upper_right;
        logic [COLOR_W-1:0] lower_left;
        logic [COLOR_W-1:0] lower_right;
    } corner_colors_t;

    // Pipeline payloads between stages
    typedef struct packed {
        weight_t     wx;
        weight_t     wy;
        chan_t       intensity;
    } coord_stage_t;

    typedef struct packed {
        chan_t [NUM_CHAN-1:0] left;
        chan_t [NUM_CHAN-1:0] right;
        weight_t              wx;
        chan_t                intensity;
    } vblend_stage_t;

    typedef struct packed {
        chan_t [NUM_CHAN-1:0] mix;
        chan_t                intensity;
    } hblend_stage_t;

    // Column weight; positions past the last column clamp to it
    function automatic col_table_t build_col_table();
        col_table_t      t;
        longint unsigned pos;
        for (int i = 0; i < COL_ENTRIES; i++) begin
            pos  = (i > COL_SPAN) ? COL_SPAN : i;
            t[i] = WEIGHT_W'((pos * ONE_Q16) / COL_SPAN);
        end
        return t;
    endfunction

    function automatic row_table_t build_row_table();
        row_table_t      t;
        longint unsigned pos;
        for (int i = 0; i < ROW_ENTRIES; i++) begin
            pos  = (i > ROW_SPAN) ? ROW_SPAN : i;
            t[i] = WEIGHT_W'((pos * ONE_Q16) / ROW_SPAN);
        end
        return t;
    endfunction

    localparam col_table_t COL_WEIGHT = build_col_table();
    localparam row_table_t ROW_WEIGHT = build_row_table();

    // floor((a*(1-w) + b*w)) rewritten as a + floor((b-a)*w), one multiply
    function automatic chan_t lerp8(chan_t a, chan_t b, weight_t w);
        logic signed [CHAN_W:0]              diff;
        logic signed [WEIGHT_W:0]            ws;
        logic signed [CHAN_W+WEIGHT_W+1:0]   prod;
        logic [CHAN_W+2:0]                   sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        ws   = $signed({1'b0, w});
        prod = diff * ws;
        sum  = {3'b000, a} + prod[CHAN_W+WEIGHT_W+1:16];
        return sum[CHAN_W-1:0];
    endfunction

endpackage

FILE: hdl/gps_coord_stage.sv
// ----------------------------------------------------------------------------
// gps_coord_stage
// Input register: looks up the column and row weights for each pixel.
// ----------------------------------------------------------------------------
module gps_coord_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  gps_pkg::pixel_t       up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output gps_pkg::coord_stage_t dn_data
);
    import gps_pkg::*;

    logic         valid_reg;
    coord_stage_t data_reg;
    coord_stage_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next.wx        = COL_WEIGHT[up_data.column];
        data_next.wy        = ROW_WEIGHT[up_data.row];
        data_next.intensity = up_data.intensity;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: hdl/gps_vblend_stage.sv
// ----------------------------------------------------------------------------
// gps_vblend_stage
// Vertical blend: mixes the upper and lower corner colors of the left and
// right edges by the row weight, per channel.
// ----------------------------------------------------------------------------
module gps_vblend_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gps_pkg::corner_colors_t colors,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  gps_pkg::coord_stage_t   up_data,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output gps_pkg::vblend_stage_t  dn_data
);
    import gps_pkg::*;

    logic          valid_reg;
    vblend_stage_t data_reg;
    vblend_stage_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            data_next.left[k]  = lerp8(colors.upper_left[k*CHAN_W +: CHAN_W],
                                       colors.lower_left[k*CHAN_W +: CHAN_W],
                                       up_data.wy);
            data_next.right[k] = lerp8(colors.upper_right[k*CHAN_W +: CHAN_W],
                                       colors.lower_right[k*CHAN_W +: CHAN_W],
                                       up_data.wy);
        end
        data_next.wx        = up_data.wx;
        data_next.intensity = up_data.intensity;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: hdl/gps_hblend_stage.sv
// ----------------------------------------------------------------------------
// gps_hblend_stage
// Horizontal blend: mixes the left and right edge colors by the column
// weight, per channel.
// ----------------------------------------------------------------------------
module gps_hblend_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  gps_pkg::vblend_stage_t up_data,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output gps_pkg::hblend_stage_t dn_data
);
    import gps_pkg::*;

    logic          valid_reg;
    hblend_stage_t data_reg;
    hblend_stage_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            data_next.mix[k] = lerp8(up_data.left[k], up_data.right[k], up_data.wx);
        end
        data_next.intensity = up_data.intensity;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: hdl/gps_scale_stage.sv
// ----------------------------------------------------------------------------
// gps_scale_stage
// Intensity scaling over two register stages: channel times intensity,
// then an exact divide by 255 and the output register.
// ----------------------------------------------------------------------------
module gps_scale_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  gps_pkg::hblend_stage_t up_data,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output gps_pkg::shade_t        dn_data
);
    import gps_pkg::*;

    localparam int unsigned PROD_W = 2 * CHAN_W;

    logic                           prod_valid_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod_next;
    logic                           prod_we_reg;
    logic                           prod_ready;

    logic                           out_valid_reg;
    shade_t                         out_reg;
    shade_t                         out_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] quot;

    assign prod_ready = !out_valid_reg || dn_ready;
    assign up_ready   = !prod_valid_reg || prod_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            prod_next[k] = PROD_W'(up_data.mix[k]) * PROD_W'(up_data.intensity);
        end
    end

    // Exact floor(p / 255) for p up to 255*255: (p + (p >> 8) + 1) >> 8
    always_comb
    begin
        logic [PROD_W:0] acc;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            acc     = {1'b0, prod_reg[k]} + (PROD_W+1)'(prod_reg[k][PROD_W-1:CHAN_W])
                      + (PROD_W+1)'(1);
            quot[k] = acc[PROD_W-1:CHAN_W];
        end
        out_next.write_enable = prod_we_reg;
        out_next.red          = quot[2];
        out_next.green        = quot[1];
        out_next.blue         = quot[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                prod_valid_reg <= up_valid;
            end
            if (prod_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg    <= prod_next;
            prod_we_reg <= (up_data.intensity != '0);
        end
        if (prod_ready && prod_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign dn_valid = out_valid_reg;
    assign dn_data  = out_reg;

endmodule

FILE: hdl/gradient_palette_shader.sv
// ----------------------------------------------------------------------------
// gradient_palette_shader
// Bilinear corner-color gradient with per-pixel intensity scaling.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled and returns
// one shaded pixel per accepted pixel, in order. The five register stages
// are: weight lookup (constant tables for column and row, clamped at the
// frame edge), vertical blend, horizontal blend, channel-times-intensity
// multiply, and divide by 255 into the output register. A stall on the
// output holds every occupied stage that has no empty stage between it and
// the output; empty stages keep filling. Zero intensity yields write_enable
// low and zero channels. The four corner colors sit in APB registers at
// byte offsets 0x0 (upper left), 0x4 (upper right), 0x8 (lower left) and
// 0xC (lower right), red in bits 23:16, green 15:8, blue 7:0; write them
// only while no pixel is in flight.
// ----------------------------------------------------------------------------
module gradient_palette_shader (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gps_pkg::PADDR_W-1:0]   paddr,
    input  logic [gps_pkg::PDATA_W-1:0]   pwdata,
    output logic [gps_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  gps_pkg::pixel_t               pixel,
    output logic                          shade_valid,
    input  logic                          shade_ready,
    output gps_pkg::shade_t               shade
);
    import gps_pkg::*;

    corner_colors_t colors_reg;
    corner_colors_t colors_next;
    reg_index_t     reg_index;
    logic           cfg_write;

    logic          coord_valid;
    logic          coord_ready;
    coord_stage_t  coord_data;
    logic          vblend_valid;
    logic          vblend_ready;
    vblend_stage_t vblend_data;
    logic          hblend_valid;
    logic          hblend_ready;
    hblend_stage_t hblend_data;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        colors_next = colors_reg;
        prdata      = '0;
        unique case (reg_index)
            REG_UPPER_LEFT:
            begin
                colors_next.upper_left = pwdata[COLOR_W-1:0];
                prdata = PDATA_W'(colors_reg.upper_left);
            end
            REG_UPPER_RIGHT:
            begin
                colors_next.upper_right = pwdata[COLOR_W-1:0];
                prdata = PDATA_W'(colors_reg.upper_right);
            end
            REG_LOWER_LEFT:
            begin
                colors_next.lower_left = pwdata[COLOR_W-1:0];
                prdata = PDATA_W'(colors_reg.lower_left);
            end
            REG_LOWER_RIGHT:
            begin
                colors_next.lower_right = pwdata[COLOR_W-1:0];
                prdata = PDATA_W'(colors_reg.lower_right);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg.upper_left  <= UPPER_LEFT_RESET;
            colors_reg.upper_right <= UPPER_RIGHT_RESET;
            colors_reg.lower_left  <= LOWER_LEFT_RESET;
            colors_reg.lower_right <= LOWER_RIGHT_RESET;
        end
        else if (cfg_write)
        begin
            colors_reg <= colors_next;
        end
    end

    gps_coord_stage u_coord (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_ready (pixel_ready),
        .up_data  (pixel),
        .dn_valid (coord_valid),
        .dn_ready (coord_ready),
        .dn_data  (coord_data)
    );

    gps_vblend_stage u_vblend (
        .clk      (clk),
        .rst_n    (rst_n),
        .colors   (colors_reg),
        .up_valid (coord_valid),
        .up_ready (coord_ready),
        .up_data  (coord_data),
        .dn_valid (vblend_valid),
        .dn_ready (vblend_ready),
        .dn_data  (vblend_data)
    );

    gps_hblend_stage u_hblend (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vblend_valid),
        .up_ready (vblend_ready),
        .up_data  (vblend_data),
        .dn_valid (hblend_valid),
        .dn_ready (hblend_ready),
        .dn_data  (hblend_data)
    );

    gps_scale_stage u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hblend_valid),
        .up_ready (hblend_ready),
        .up_data  (hblend_data),
        .dn_valid (shade_valid),
        .dn_ready (shade_ready),
        .dn_data  (shade)
    );

endmodule
